// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is low
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/tsct_pkg.sv =====
// shared constants and types for the touch sample calibration block
package tsct_pkg;

    localparam int SCREEN_WIDTH  = 240;
    localparam int SCREEN_HEIGHT = 320;

    localparam int RAW_W    = 12;
    localparam int RAW_MAX  = (1 << RAW_W) - 1;
    localparam int MAX_SIZE = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
    localparam int SIZE_W   = $clog2(MAX_SIZE + 1);
    localparam int NUM_W    = $clog2(RAW_MAX * MAX_SIZE + 1);
    localparam int CNT_W    = $clog2(NUM_W + 1);
    localparam int X_W      = $clog2(SCREEN_WIDTH);
    localparam int Y_W      = $clog2(SCREEN_HEIGHT);

    localparam logic [1:0] ST_RELEASED = 2'd0;
    localparam logic [1:0] ST_PRESSED  = 2'd1;
    localparam logic [1:0] ST_HELD     = 2'd2;

    localparam logic [2:0] REG_X_MIN    = 3'd0;
    localparam logic [2:0] REG_X_MAX    = 3'd1;
    localparam logic [2:0] REG_Y_MIN    = 3'd2;
    localparam logic [2:0] REG_Y_MAX    = 3'd3;
    localparam logic [2:0] REG_ORIENT   = 3'd4;
    localparam logic [2:0] REG_ENABLE   = 3'd5;
    localparam logic [2:0] REG_THRESH   = 3'd6;
    localparam logic [2:0] REG_DEBOUNCE = 3'd7;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] dividend;
        logic [RAW_W-1:0] divisor;
    } div_req_t;

endpackage

// ===== rtl/tsct_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
module tsct_div import tsct_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  div_req_t         req,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] q_reg, q_next;
    logic [RAW_W-1:0] rem_reg, rem_next;
    logic [RAW_W-1:0] d_reg, d_next;
    logic [RAW_W:0]   rem_sh;
    logic [RAW_W:0]   rem_sub;
    logic             fits;

    assign rem_sh  = {rem_reg, q_reg[NUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, d_reg};
    assign fits    = (rem_sh >= {1'b0, d_reg});

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = busy_reg && (cnt_reg == CNT_W'(1));
        q_next    = q_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            q_next    = req.dividend;
            rem_next  = '0;
            d_next    = req.divisor;
        end else if (busy_reg) begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
            q_next   = {q_reg[NUM_W-2:0], fits};
            rem_next = fits ? rem_sub[RAW_W-1:0] : rem_sh[RAW_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== rtl/touch_sample_calibrate_track.sv =====
// touch sample calibration and press/release tracking, top level
//
// one raw touch sample per input item on the s_ channel, one result item
// per sample on the m_ channel; configuration registers are written
// through cfg_we/cfg_index/cfg_wdata, and the user must write them only
// while the block is idle; the block itself does not enforce it.
// a touched sample maps both axes through one shared bit-serial divider
// that produces a 21-bit quotient one bit a cycle, passing through the
// states map x, divide x, map y, divide y and finish in that order; a
// sample with no touch, a failed read or disabled sampling goes from
// idle straight to the finish state and does not use the divider.
// one sample is in work at a time; s_tready is high only while idle.
// the result sits in an output register until taken, and the next sample
// is accepted while it waits; a new result is loaded only once the
// previous one has been taken, so a stalled receiver holds the block.
// reset loads the default calibration (span 200..3900, threshold 100,
// debounce 50 ms, sampling on), clears the press counter, time stamps
// and held coordinates and returns the tracked state to released.
module touch_sample_calibrate_track import tsct_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,   // raw_x, raw_y, raw_pressure, now_ms, zero pad
    input  logic         s_tuser,   // read_failed
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // pos_col, pos_row, touch_pressure, touch_valid,
                                    // shown_state, touch_time_ms, press_count, last_press_ms
    output logic         m_tuser,   // status
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_wdata
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MAPX = 3'd1;
    localparam logic [2:0] S_DIVX = 3'd2;
    localparam logic [2:0] S_MAPY = 3'd3;
    localparam logic [2:0] S_DIVY = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    localparam logic [SIZE_W-1:0] SIZE_X = SIZE_W'(SCREEN_WIDTH);
    localparam logic [SIZE_W-1:0] SIZE_Y = SIZE_W'(SCREEN_HEIGHT);

    function automatic logic [SIZE_W-1:0] fit_axis(input logic [NUM_W-1:0] q,
                                                   input logic neg,
                                                   input logic zero,
                                                   input logic inv,
                                                   input logic [SIZE_W-1:0] size);
        logic signed [NUM_W+1:0] v;
        logic signed [NUM_W+1:0] sz;
        logic [SIZE_W-1:0]       res;
        sz = signed'({{(NUM_W+2-SIZE_W){1'b0}}, size});
        v  = signed'({2'b00, q});
        if (neg) begin
            v = -v;
        end
        if (zero) begin
            v = '0;
        end
        if (inv) begin
            v = sz - v - signed'({{(NUM_W+1){1'b0}}, 1'b1});
        end
        if (v[NUM_W+1]) begin
            res = '0;
        end else if (v >= sz) begin
            res = size - SIZE_W'(1);
        end else begin
            res = v[SIZE_W-1:0];
        end
        return res;
    endfunction

    // configuration
    logic [RAW_W-1:0] x_min_reg, x_max_reg, y_min_reg, y_max_reg, thresh_reg;
    logic [2:0]       orient_reg;
    logic             enable_reg;
    logic [15:0]      debounce_reg;

    // control and tracked state
    logic [2:0]       state_reg, state_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [1:0]       tracked_reg, tracked_next;
    logic [1:0]       reported_reg, reported_next;
    logic [X_W-1:0]   held_x_reg, held_x_next;
    logic [Y_W-1:0]   held_y_reg, held_y_next;
    logic [RAW_W-1:0] held_p_reg, held_p_next;
    logic             valid_reg, valid_next;
    logic [31:0]      touch_stamp_reg, touch_stamp_next;
    logic [31:0]      press_total_reg, press_total_next;
    logic [31:0]      press_stamp_reg, press_stamp_next;
    logic             status_reg, status_next;

    // sample payload
    logic [RAW_W-1:0] rx_reg, ry_reg, pr_reg;
    logic [31:0]      now_reg;
    logic             fail_reg;
    logic             neg_reg, neg_next;
    logic             zero_reg, zero_next;
    logic [X_W-1:0]   x_res_reg, x_res_next;
    logic [Y_W-1:0]   y_res_reg, y_res_next;

    logic             accept;
    logic             touch_in;
    logic             sel_y;
    logic [RAW_W-1:0] raw_a, lo_a, hi_a;
    logic [SIZE_W-1:0] size_a;
    logic             diff_neg, span_neg;
    logic [RAW_W-1:0] diff_mag, span_mag;
    logic [NUM_W-1:0] num_mag;
    logic [SIZE_W-1:0] fit_val;
    logic [31:0]      elapsed;
    logic             touch_now;
    logic             div_done;
    logic [NUM_W-1:0] div_q;
    div_req_t         div_req;

    assign accept   = s_tvalid && s_tready;
    assign touch_in = enable_reg && !s_tuser && (s_tdata[35:24] >= thresh_reg);

    // operand selection for the axis being mapped
    assign sel_y  = (state_reg == S_MAPY) || (state_reg == S_DIVY);
    assign raw_a  = (sel_y ^ orient_reg[0]) ? ry_reg : rx_reg;
    assign lo_a   = sel_y ? y_min_reg : x_min_reg;
    assign hi_a   = sel_y ? y_max_reg : x_max_reg;
    assign size_a = sel_y ? SIZE_Y : SIZE_X;

    assign diff_neg = (raw_a < lo_a);
    assign diff_mag = diff_neg ? (lo_a - raw_a) : (raw_a - lo_a);
    assign span_neg = (hi_a < lo_a);
    assign span_mag = span_neg ? (lo_a - hi_a) : (hi_a - lo_a);
    assign num_mag  = {{(NUM_W-RAW_W){1'b0}}, diff_mag} * {{(NUM_W-SIZE_W){1'b0}}, size_a};

    assign div_req.start    = (state_reg == S_MAPX) || (state_reg == S_MAPY);
    assign div_req.dividend = num_mag;
    assign div_req.divisor  = span_mag;

    tsct_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    assign fit_val = fit_axis(div_q, neg_reg, zero_reg,
                              sel_y ? orient_reg[2] : orient_reg[1], size_a);
    assign elapsed   = now_reg - touch_stamp_reg;
    assign touch_now = enable_reg && !fail_reg && (pr_reg >= thresh_reg);

    always_comb begin
        state_next       = state_reg;
        m_tvalid_next    = m_tvalid_reg;
        tracked_next     = tracked_reg;
        reported_next    = reported_reg;
        held_x_next      = held_x_reg;
        held_y_next      = held_y_reg;
        held_p_next      = held_p_reg;
        valid_next       = valid_reg;
        touch_stamp_next = touch_stamp_reg;
        press_total_next = press_total_reg;
        press_stamp_next = press_stamp_reg;
        status_next      = status_reg;
        neg_next         = neg_reg;
        zero_next        = zero_reg;
        x_res_next       = x_res_reg;
        y_res_next       = y_res_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = touch_in ? S_MAPX : S_FIN;
                end
            end
            S_MAPX, S_MAPY: begin
                neg_next   = diff_neg ^ span_neg;
                zero_next  = (span_mag == '0);
                state_next = (state_reg == S_MAPX) ? S_DIVX : S_DIVY;
            end
            S_DIVX: begin
                if (div_done) begin
                    x_res_next = fit_val[X_W-1:0];
                    state_next = S_MAPY;
                end
            end
            S_DIVY: begin
                if (div_done) begin
                    y_res_next = fit_val[Y_W-1:0];
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                    status_next   = 1'b0;
                    if (!enable_reg || fail_reg) begin
                        valid_next    = 1'b0;
                        reported_next = ST_RELEASED;
                        status_next   = enable_reg && fail_reg;
                    end else if (touch_now) begin
                        held_x_next      = x_res_reg;
                        held_y_next      = y_res_reg;
                        held_p_next      = pr_reg;
                        valid_next       = 1'b1;
                        touch_stamp_next = now_reg;
                        if (tracked_reg == ST_RELEASED) begin
                            reported_next    = ST_PRESSED;
                            tracked_next     = ST_PRESSED;
                            press_total_next = press_total_reg + 32'd1;
                            press_stamp_next = now_reg;
                        end else begin
                            reported_next = ST_HELD;
                            tracked_next  = ST_HELD;
                        end
                    end else begin
                        held_p_next = '0;
                        valid_next  = 1'b0;
                        if ((tracked_reg != ST_RELEASED) &&
                            (elapsed >= {16'd0, debounce_reg})) begin
                            reported_next = ST_RELEASED;
                            tracked_next  = ST_RELEASED;
                        end
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_min_reg    <= RAW_W'(200);
            x_max_reg    <= RAW_W'(3900);
            y_min_reg    <= RAW_W'(200);
            y_max_reg    <= RAW_W'(3900);
            orient_reg   <= '0;
            enable_reg   <= 1'b1;
            thresh_reg   <= RAW_W'(100);
            debounce_reg <= 16'd50;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_X_MIN:    x_min_reg    <= cfg_wdata[RAW_W-1:0];
                REG_X_MAX:    x_max_reg    <= cfg_wdata[RAW_W-1:0];
                REG_Y_MIN:    y_min_reg    <= cfg_wdata[RAW_W-1:0];
                REG_Y_MAX:    y_max_reg    <= cfg_wdata[RAW_W-1:0];
                REG_ORIENT:   orient_reg   <= cfg_wdata[2:0];
                REG_ENABLE:   enable_reg   <= cfg_wdata[0];
                REG_THRESH:   thresh_reg   <= cfg_wdata[RAW_W-1:0];
                REG_DEBOUNCE: debounce_reg <= cfg_wdata;
                default:      debounce_reg <= debounce_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            m_tvalid_reg    <= 1'b0;
            tracked_reg     <= ST_RELEASED;
            reported_reg    <= ST_RELEASED;
            held_x_reg      <= '0;
            held_y_reg      <= '0;
            held_p_reg      <= '0;
            valid_reg       <= 1'b0;
            touch_stamp_reg <= '0;
            press_total_reg <= '0;
            press_stamp_reg <= '0;
            status_reg      <= 1'b0;
        end else begin
            state_reg       <= state_next;
            m_tvalid_reg    <= m_tvalid_next;
            tracked_reg     <= tracked_next;
            reported_reg    <= reported_next;
            held_x_reg      <= held_x_next;
            held_y_reg      <= held_y_next;
            held_p_reg      <= held_p_next;
            valid_reg       <= valid_next;
            touch_stamp_reg <= touch_stamp_next;
            press_total_reg <= press_total_next;
            press_stamp_reg <= press_stamp_next;
            status_reg      <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rx_reg   <= s_tdata[11:0];
            ry_reg   <= s_tdata[23:12];
            pr_reg   <= s_tdata[35:24];
            now_reg  <= s_tdata[67:36];
            fail_reg <= s_tuser;
        end
        neg_reg   <= neg_next;
        zero_reg  <= zero_next;
        x_res_reg <= x_res_next;
        y_res_reg <= y_res_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {press_stamp_reg, press_total_reg, touch_stamp_reg,
                       reported_reg, valid_reg, held_p_reg, held_y_reg, held_x_reg};
    assign m_tuser  = status_reg;

endmodule

// ===== rtl/tsct_chk.sv =====
// port-level checker for the touch sample calibration block, with its bind
`include "assert_macros.svh"

module tsct_chk import tsct_pkg::*; (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic         m_tuser
);

    logic [X_W-1:0] col;
    logic [Y_W-1:0] row;
    logic           vld;
    logic [1:0]     shown;
    logic           tracked;
    logic           on_screen;

    assign col       = m_tdata[7:0];
    assign row       = m_tdata[16:8];
    assign vld       = m_tdata[29];
    assign shown     = m_tdata[31:30];
    assign tracked   = (shown == ST_PRESSED) || (shown == ST_HELD);
    assign on_screen = (32'(col) < SCREEN_WIDTH) && (32'(row) < SCREEN_HEIGHT);

    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `ASSERT_IMPLY(a_fail_rel, aclk, aresetn, m_tvalid && m_tuser, !vld && (shown == ST_RELEASED))
    `ASSERT_IMPLY(a_valid_tracked, aclk, aresetn, m_tvalid && vld, tracked)
    `ASSERT_IMPLY(a_on_screen, aclk, aresetn, m_tvalid, on_screen)
    `ASSERT_NEXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready)

endmodule

bind touch_sample_calibrate_track tsct_chk u_tsct_chk (.*);
